### rtl/core/lsu_pkg.sv
package lsu_pkg;

  // Width of the internal decoded-byte counter (8 to 32).
  localparam int unsigned LengthBits = 16;
  localparam int unsigned OutLenBits = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  typedef logic [LengthBits-1:0] length_t;

  // Character codes
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChSeven  = 8'h37;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChFf     = 8'h0C;

  typedef enum logic [2:0] {
    ModeNormal = 3'b001,
    ModeEscape = 3'b010,
    ModeOctal  = 3'b100
  } mode_e;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  byte_valid;
    logic                  end_mark;
    logic [OutLenBits-1:0] out_length;
  } lsu_result_t;

  // Up to two result words produced by one input byte.
  typedef struct packed {
    logic [1:0]             num;
    lsu_result_t [1:0]      slot;
  } lsu_emit_t;

  function automatic length_t sat_inc(length_t v, logic inc);
    sat_inc = (inc && (v != {LengthBits{1'b1}})) ? v + length_t'(1) : v;
  endfunction

endpackage

### rtl/core/lsu_decode.sv
module lsu_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic               last_in_i,
  output lsu_pkg::lsu_emit_t emit_o
);
  import lsu_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] oct_val_q, oct_val_d;
  logic [1:0] oct_cnt_q, oct_cnt_d;
  length_t    len_q, len_d;

  logic       is_oct;
  logic [2:0] digit;
  logic [7:0] oct_next;
  logic       a_vld, b_vld;
  logic [7:0] a_byte, b_byte;
  logic       c_vld;
  logic       s0_vld;
  logic [7:0] s0_byte;
  length_t    len0, len1;

  assign is_oct   = (in_byte_i >= ChZero) && (in_byte_i <= ChSeven);
  assign digit    = in_byte_i[2:0];
  assign oct_next = {oct_val_q[4:0], digit};

  always_comb begin
    mode_d    = mode_q;
    oct_val_d = oct_val_q;
    oct_cnt_d = oct_cnt_q;
    a_vld     = 1'b0;
    a_byte    = in_byte_i;
    b_vld     = 1'b0;
    b_byte    = in_byte_i;
    case (mode_q)
      ModeEscape: begin
        mode_d = ModeNormal;
        a_vld  = 1'b1;
        case (in_byte_i)
          ChLowN:  a_byte = ChLf;
          ChLowR:  a_byte = ChCr;
          ChLowT:  a_byte = ChTab;
          ChLowB:  a_byte = ChBs;
          ChLowF:  a_byte = ChFf;
          default: begin
            if (is_oct) begin
              a_vld     = 1'b0;
              mode_d    = ModeOctal;
              oct_val_d = {5'd0, digit};
              oct_cnt_d = 2'd1;
            end
          end
        endcase
      end
      ModeOctal: begin
        if (is_oct) begin
          if (oct_cnt_q == 2'd2) begin
            // third digit: emit now
            a_vld     = 1'b1;
            a_byte    = oct_next;
            mode_d    = ModeNormal;
            oct_val_d = '0;
            oct_cnt_d = '0;
          end else begin
            oct_val_d = oct_next;
            oct_cnt_d = oct_cnt_q + 2'd1;
          end
        end else begin
          // flush pending digits, then handle the byte as plain text
          a_vld     = 1'b1;
          a_byte    = oct_val_q;
          oct_val_d = '0;
          oct_cnt_d = '0;
          if (in_byte_i == ChBslash) begin
            mode_d = ModeEscape;
          end else begin
            mode_d = ModeNormal;
            b_vld  = 1'b1;
          end
        end
      end
      default: begin
        mode_d = ModeNormal;
        if (in_byte_i == ChBslash) begin
          mode_d = ModeEscape;
        end else begin
          a_vld = 1'b1;
        end
      end
    endcase
  end

  // At end of string, flush octal digits still pending.
  assign c_vld   = last_in_i && (mode_d == ModeOctal);
  assign s0_vld  = a_vld || c_vld;
  assign s0_byte = a_vld ? a_byte : (c_vld ? oct_val_d : 8'd0);
  assign len0    = sat_inc(len_q, s0_vld);
  assign len1    = sat_inc(len0, b_vld);

  always_comb begin
    emit_o.slot[0].out_byte   = s0_byte;
    emit_o.slot[0].byte_valid = s0_vld;
    emit_o.slot[0].end_mark   = last_in_i && !b_vld;
    emit_o.slot[0].out_length = OutLenBits'(len0);
    emit_o.slot[1].out_byte   = b_byte;
    emit_o.slot[1].byte_valid = 1'b1;
    emit_o.slot[1].end_mark   = last_in_i;
    emit_o.slot[1].out_length = OutLenBits'(len1);
    if (b_vld) begin
      emit_o.num = 2'd2;
    end else if (s0_vld || last_in_i) begin
      emit_o.num = 2'd1;
    end else begin
      emit_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeNormal;
      oct_val_q <= '0;
      oct_cnt_q <= '0;
      len_q     <= '0;
    end else if (accept_i) begin
      if (last_in_i) begin
        mode_q    <= ModeNormal;
        oct_val_q <= '0;
        oct_cnt_q <= '0;
        len_q     <= '0;
      end else begin
        mode_q    <= mode_d;
        oct_val_q <= oct_val_d;
        oct_cnt_q <= oct_cnt_d;
        len_q     <= len1;
      end
    end
  end

endmodule

### rtl/core/literal_string_unescape.sv
// Channel | Handshake                  | Payload
// --------+----------------------------+------------------------------------------------
// in      | in_valid_i / in_ready_o    | in_byte_i, last_in_i
// out     | out_valid_o / out_ready_i  | out_byte_o, byte_valid_o, end_mark_o, out_length_o
//
// One input word per cycle is taken while in_ready_o is high; it is decoded in the same
// cycle into zero, one or two result words that land in a four-entry result queue.
// Results show the cycle after acceptance; one leaves per cycle while out_ready_i is high.
// in_ready_o is decoded from the registered queue count: high while two words or fewer wait.
// Reset clears the escape state, the length counter and the queue.
module literal_string_unescape (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          byte_valid_o,
  output logic                          end_mark_o,
  output logic [lsu_pkg::OutLenBits-1:0] out_length_o
);
  import lsu_pkg::*;

  logic        in_fire;
  logic        out_fire;
  lsu_emit_t   emit;

  lsu_result_t                queue_q [QueueDepth];
  logic [QueuePtrBits-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QueuePtrBits:0]      count_q;
  logic [1:0]                 push_num;
  logic [QueuePtrBits-1:0]    wr_ptr_nx;

  assign in_ready_o  = count_q <= (QueuePtrBits+1)'(QueueDepth - 2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = count_q != '0;
  assign out_fire    = out_valid_o && out_ready_i;
  assign push_num    = in_fire ? emit.num : 2'd0;
  assign wr_ptr_nx   = wr_ptr_q + QueuePtrBits'(1);

  lsu_decode u_decode (
    .clk_i,
    .rst_ni,
    .accept_i  (in_fire),
    .in_byte_i,
    .last_in_i,
    .emit_o    (emit)
  );

  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      queue_q[wr_ptr_q] <= emit.slot[0];
    end
    if (push_num == 2'd2) begin
      queue_q[wr_ptr_nx] <= emit.slot[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrBits'(push_num);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrBits'(1);
      end
      count_q <= count_q + (QueuePtrBits+1)'(push_num)
               - (QueuePtrBits+1)'(out_fire);
    end
  end

  assign out_byte_o   = queue_q[rd_ptr_q].out_byte;
  assign byte_valid_o = queue_q[rd_ptr_q].byte_valid;
  assign end_mark_o   = queue_q[rd_ptr_q].end_mark;
  assign out_length_o = queue_q[rd_ptr_q].out_length;

endmodule

### verif/testbench.sv
module testbench;
  import lsu_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_byte = 8'h00;
  logic                  last_in = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_byte;
  logic                  byte_valid;
  logic                  end_mark;
  logic [OutLenBits-1:0] out_length;

  literal_string_unescape dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_byte_i    (in_byte),
    .last_in_i    (last_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .byte_valid_o (byte_valid),
    .end_mark_o   (end_mark),
    .out_length_o (out_length)
  );

  always #2 clk = ~clk;

  // Decoder shadow state
  mode_e       dec_mode = ModeNormal;
  logic [7:0]  oct_val = 8'h00;
  logic [1:0]  oct_cnt = 2'd0;
  length_t     dec_len = '0;
  int          emit_cnt;

  lsu_result_t decoded_words[$];
  logic [7:0]  string_buf[$];

  int send_idle = 0;
  int recv_stall = 0;
  int mismatches = 0;
  int words_sent = 0;
  int strings_sent = 0;
  int results_checked = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    string_buf.insert(string_buf.size(), b);
  endtask

  task automatic push_decoded(input logic [7:0] b, input logic v);
    lsu_result_t r;
    if (v && dec_len != {LengthBits{1'b1}}) dec_len = dec_len + 1'b1;
    r.out_byte   = v ? b : 8'h00;
    r.byte_valid = v;
    r.end_mark   = 1'b0;
    r.out_length = dec_len[OutLenBits-1:0];
    decoded_words.insert(decoded_words.size(), r);
    emit_cnt++;
  endtask

  task automatic flush_pending_octal();
    if (oct_cnt != 2'd0) push_decoded(oct_val, 1'b1);
    oct_val  = 8'h00;
    oct_cnt  = 2'd0;
    dec_mode = ModeNormal;
  endtask

  task automatic take_plain(input logic [7:0] b);
    if (b == ChBslash) dec_mode = ModeEscape;
    else push_decoded(b, 1'b1);
  endtask

  task automatic decode_word(input logic [7:0] b, input logic last);
    logic        is_oct;
    lsu_result_t r;
    is_oct   = (b >= ChZero) && (b <= ChSeven);
    emit_cnt = 0;
    if (dec_mode == ModeEscape) begin
      dec_mode = ModeNormal;
      case (b)
        ChLowN: push_decoded(ChLf, 1'b1);
        ChLowR: push_decoded(ChCr, 1'b1);
        ChLowT: push_decoded(ChTab, 1'b1);
        ChLowB: push_decoded(ChBs, 1'b1);
        ChLowF: push_decoded(ChFf, 1'b1);
        default: begin
          if (is_oct) begin
            dec_mode = ModeOctal;
            oct_val  = {5'b0, b[2:0]};
            oct_cnt  = 2'd1;
          end else begin
            push_decoded(b, 1'b1);
          end
        end
      endcase
    end else if (dec_mode == ModeOctal) begin
      if (is_oct) begin
        oct_val = (oct_val << 3) + {5'b0, b[2:0]};
        oct_cnt = oct_cnt + 2'd1;
        if (oct_cnt == 2'd3) flush_pending_octal();
      end else begin
        flush_pending_octal();
        take_plain(b);
      end
    end else begin
      take_plain(b);
    end
    if (last) begin
      if (dec_mode == ModeOctal) flush_pending_octal();
      if (emit_cnt == 0) push_decoded(8'h00, 1'b0);
      // mark the final word of the string
      r = decoded_words.pop_back();
      r.end_mark = 1'b1;
      decoded_words.insert(decoded_words.size(), r);
      dec_mode = ModeNormal;
      oct_val  = 8'h00;
      oct_cnt  = 2'd0;
      dec_len  = '0;
    end
  endtask

  // Call at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    last_in  <= last;
    do @(posedge clk); while (!in_ready);
    decode_word(b, last);
    words_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_buffer();
    for (int i = 0; i < string_buf.size(); i++) begin
      send_word(string_buf[i], i == string_buf.size() - 1);
    end
    string_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    send_buffer();
  endtask

  // Sample on the edge; DUT outputs still hold their pre-edge values here.
  always @(posedge clk) begin
    lsu_result_t want;
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
    if (rst_n && out_valid && out_ready) begin
      if (decoded_words.size() == 0) begin
        report_mismatch("unexpected word, out_byte", out_byte, 0);
      end else begin
        want = decoded_words.pop_front();
        results_checked++;
        if (out_byte !== want.out_byte)
          report_mismatch("out_byte", out_byte, want.out_byte);
        if (byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", byte_valid, want.byte_valid);
        if (end_mark !== want.end_mark)
          report_mismatch("end_mark", end_mark, want.end_mark);
        if (out_length !== want.out_length)
          report_mismatch("out_length", out_length, want.out_length);
      end
    end
  end

  task automatic test_plain_extremes();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_control_escapes();
    send_text("\\n\\r\\t\\b\\f");
    send_text("\\8");
  endtask

  task automatic test_octal_escapes();
    // third digit closes at once, then a non-octal flush, then flush at end
    send_text("\\777");
    send_text("\\12A");
    send_text("\\4");
    send_text("\\1\\");
  endtask

  task automatic test_trailing_backslash();
    send_text("\\");
  endtask

  task automatic build_random_string();
    int pieces;
    int kind;
    int ndig;
    logic [7:0] letters [5];
    letters = '{ChLowN, ChLowR, ChLowT, ChLowB, ChLowF};
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes heavy in backslashes and digits
      for (int i = 0; i < pieces; i++) begin
        kind = $urandom_range(0, 2);
        add_byte(kind == 0 ? ChBslash :
                 kind == 1 ? 8'(ChZero + $urandom_range(0, 9)) :
                 8'($urandom_range(0, 255)));
      end
      return;
    end
    for (int i = 0; i < pieces; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: add_byte(8'($urandom_range(0, 255)));
        4: begin
          add_byte(ChBslash);
          add_byte(letters[$urandom_range(0, 4)]);
        end
        5: begin
          add_byte(ChBslash);
          add_byte(8'($urandom_range(0, 255)));
        end
        6, 7: begin
          ndig = $urandom_range(1, 3);
          add_byte(ChBslash);
          for (int d = 0; d < ndig; d++)
            add_byte(8'(ChZero + $urandom_range(0, 7)));
        end
        8: begin
          add_byte(ChBslash);
          add_byte($urandom_range(0, 1) ? ChBslash : 8'h28);
        end
        default: add_byte(8'(ChZero + $urandom_range(0, 7)));
      endcase
    end
    if ($urandom_range(0, 7) == 0) add_byte(ChBslash);
  endtask

  task automatic test_random_streams(input int idle_pct, input int stall_pct,
                                     input int nwords);
    int start;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    start = words_sent;
    while (words_sent - start < nwords) begin
      build_random_string();
      send_buffer();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle  = 7;
    recv_stall = 7;
    test_plain_extremes();
    test_control_escapes();
    test_octal_escapes();
    test_trailing_backslash();

    test_random_streams(0, 0, 290);
    test_random_streams(73, 0, 290);
    test_random_streams(0, 73, 290);
    test_random_streams(7, 7, 290);

    in_valid   <= 1'b0;
    recv_stall = 0;
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d strings, %0d input words, %0d result words checked",
             strings_sent, words_sent, results_checked);
    $display("summary: escapes, octal runs, trailing backslash, idle and stall mixes; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
